// ===== design/tdwa_pkg.sv =====
// shared types, constants and a helper function for the time-of-day window alarm
package tdwa_pkg;

  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [16:0] HourSeconds  = 17'd3600;
  localparam logic [16:0] MinSeconds   = 17'd60;
  localparam logic [16:0] DaySeconds   = 17'd86400;
  localparam logic [16:0] HalfDayLimit = 17'd43199;
  localparam logic [16:0] NoonTarget   = 17'd43230;
  localparam logic [15:0] NoonWindow   = 16'd30;
  localparam logic [5:0]  TickLimit    = 6'd59;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DAWN_HOUR     = 3'd0,
    CFG_DAWN_MINUTE   = 3'd1,
    CFG_SUNSET_HOUR   = 3'd2,
    CFG_SUNSET_MINUTE = 3'd3,
    CFG_MATCH_WINDOW  = 3'd4,
    CFG_EVENT_ID      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } tdwa_in_t;

  typedef struct packed {
    logic        checked;
    logic        fire_noon;
    logic        fire_dawn;
    logic        fire_sunset;
    logic [16:0] day_second;
  } tdwa_out_t;

  typedef struct packed {
    logic [16:0] dawn_target;
    logic [16:0] sunset_target;
    logic [15:0] match_window;
    logic        event_en;
  } tdwa_cfg_t;

  function automatic logic [16:0] day_sec(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    logic [16:0] acc;
    acc = 17'(h) * HourSeconds + 17'(m) * MinSeconds + 17'(s);
    return acc;
  endfunction

endpackage

// ===== design/time_of_day_window_alarm_unit.sv =====
// top level of the time-of-day window alarm
//
// input channel: one beat per frame tick carrying hour, minute and second
// (in_valid_i / in_ready_o / in_data_i). output channel: one result beat per
// input beat, in order (out_valid_o / out_ready_i / out_data_o).
// configuration channel: cfg_valid_i / cfg_ready_o with register index and
// data; cfg_ready_o is always high, and writes are registered as they are taken.
// path: an input beat is taken into the input register, and its result loads
// into the result register once that register is empty or being taken, so a
// stall can come between the two (input register, then result register).
// throughput: one beat per cycle while out_ready_i is high; the window
// compares and the constant multiplies for the second of the day sit between
// those two registers. every 60th tick is skipped with an all-zero result.
// reset: frame counter cleared, all three windows armed, registers at their
// defaults, both stages empty.
// stall: when out_ready_i is low the result holds; an empty input register
// still takes one more beat, then in_ready_o drops until the result is taken.
module time_of_day_window_alarm_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tdwa_pkg::tdwa_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tdwa_pkg::tdwa_out_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tdwa_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import tdwa_pkg::*;

  tdwa_cfg_t   cfg;
  logic        in_vld_q, out_vld_q;
  tdwa_in_t    in_q;
  tdwa_out_t   out_q, out_d;
  logic [5:0]  tick_q, tick_d;
  logic        move, skip, eval_en;
  logic [16:0] t;
  logic        hit_noon, hit_dawn, hit_sunset;

  assign cfg_ready_o = 1'b1;

  tdwa_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign move       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || move;
  assign skip       = (tick_q >= TickLimit);
  assign eval_en    = move && !skip;
  assign tick_d     = skip ? 6'd0 : (tick_q + 6'd1);
  assign t          = day_sec(in_q.now_hour, in_q.now_minute, in_q.now_second);

  tdwa_window u_noon (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eval_en_i (eval_en),
    .t_i       (t),
    .target_i  (NoonTarget),
    .window_i  (NoonWindow),
    .fire_o    (hit_noon)
  );

  tdwa_window u_dawn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eval_en_i (eval_en),
    .t_i       (t),
    .target_i  (cfg.dawn_target),
    .window_i  (cfg.match_window),
    .fire_o    (hit_dawn)
  );

  tdwa_window u_sunset (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eval_en_i (eval_en),
    .t_i       (t),
    .target_i  (cfg.sunset_target),
    .window_i  (cfg.match_window),
    .fire_o    (hit_sunset)
  );

  always_comb begin
    out_d = '0;
    if (!skip) begin
      out_d.checked     = 1'b1;
      out_d.fire_noon   = cfg.event_en && hit_noon;
      out_d.fire_dawn   = cfg.event_en && hit_dawn;
      out_d.fire_sunset = cfg.event_en && hit_sunset;
      out_d.day_second  = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      tick_q    <= 6'd0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (move) begin
        out_vld_q <= 1'b1;
        tick_q    <= tick_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/tdwa_cfg_regs.sv =====
// configuration register file and derived target times
module tdwa_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [tdwa_pkg::CfgIdxWidth-1:0]     wr_index_i,
  input  logic [15:0]                          wr_data_i,
  output tdwa_pkg::tdwa_cfg_t                  cfg_o
);
  import tdwa_pkg::*;

  logic [4:0]  dawn_hour_q, sunset_hour_q;
  logic [5:0]  dawn_minute_q, sunset_minute_q;
  logic [15:0] match_window_q, event_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dawn_hour_q     <= 5'd6;
      dawn_minute_q   <= 6'd0;
      sunset_hour_q   <= 5'd18;
      sunset_minute_q <= 6'd0;
      match_window_q  <= 16'd60;
      event_id_q      <= 16'd0;
    end else if (wr_en_i) begin
      case (cfg_reg_e'(wr_index_i))
        CFG_DAWN_HOUR:     dawn_hour_q     <= wr_data_i[4:0];
        CFG_DAWN_MINUTE:   dawn_minute_q   <= wr_data_i[5:0];
        CFG_SUNSET_HOUR:   sunset_hour_q   <= wr_data_i[4:0];
        CFG_SUNSET_MINUTE: sunset_minute_q <= wr_data_i[5:0];
        CFG_MATCH_WINDOW:  match_window_q  <= wr_data_i;
        CFG_EVENT_ID:      event_id_q      <= wr_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.dawn_target   = day_sec(dawn_hour_q, dawn_minute_q, 6'd0);
    cfg_o.sunset_target = day_sec(sunset_hour_q, sunset_minute_q, 6'd0);
    cfg_o.match_window  = match_window_q;
    cfg_o.event_en      = (event_id_q != 16'd0);
  end

endmodule

// ===== design/tdwa_window.sv =====
// one target window: folded distance, compare and armed flag
module tdwa_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        eval_en_i,
  input  logic [16:0] t_i,
  input  logic [16:0] target_i,
  input  logic [15:0] window_i,
  output logic        fire_o
);
  import tdwa_pkg::*;

  logic        armed_q;
  logic [16:0] diff, fold_dist;
  logic        hit;

  always_comb begin
    diff = (t_i >= target_i) ? (t_i - target_i) : (target_i - t_i);
    if (diff > HalfDayLimit) begin
      fold_dist = (diff >= DaySeconds) ? (diff - DaySeconds) : (DaySeconds - diff);
    end else begin
      fold_dist = diff;
    end
    hit    = (fold_dist <= {1'b0, window_i});
    fire_o = hit && armed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
    end else if (eval_en_i) begin
      armed_q <= !hit;
    end
  end

endmodule

// ===== design/tdwa_checker.sv =====
// port-level checks for the time-of-day window alarm, bound to the top level
module tdwa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input tdwa_pkg::tdwa_out_t               out_data_o
);
  import tdwa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // skipped tick carries an all-zero result
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.checked |-> out_data_o == '0)
    else $error("skipped tick result not zero");

  // a fire only on an evaluated tick
  a_fire_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fire_noon || out_data_o.fire_dawn ||
    out_data_o.fire_sunset) |-> out_data_o.checked)
    else $error("fire on skipped tick");

  // empty output stage never blocks the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind time_of_day_window_alarm_unit tdwa_checker u_tdwa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
